// ===== design/rmj_pkg.sv =====
// shared types, constants and saturation helpers for the radar measurement jacobian
package rmj_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int DATA_W     = 32;
  localparam int SQ_W       = 2 * DATA_W;
  localparam int NUM_W      = DATA_W + 2 * FRAC_BITS;
  localparam int SQ_STEPS   = DATA_W;
  localparam int DIV_STEPS  = DATA_W;
  localparam int DIV_LAT    = DIV_STEPS + 1;
  localparam int MINR_W     = 31;
  localparam int FB_W       = 17;
  localparam int CFG_W      = 31;

  localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [0:0] {
    CFG_MIN_RANGE = 1'b0,
    CFG_FALLBACK  = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] vel_x;
    logic signed [DATA_W-1:0] vel_y;
  } rmj_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] range_dx;
    logic signed [DATA_W-1:0] range_dy;
    logic signed [DATA_W-1:0] bearing_dx;
    logic signed [DATA_W-1:0] bearing_dy;
    logic signed [DATA_W-1:0] rate_dx;
    logic signed [DATA_W-1:0] rate_dy;
    logic                     near_origin;
  } rmj_out_t;

  // side data carried alongside the square root
  typedef struct packed {
    logic signed [DATA_W-1:0] vel_x;
    logic signed [DATA_W-1:0] vel_y;
    logic                     px_neg;
    logic                     py_neg;
    logic                     py_pos;
    logic [DATA_W-1:0]        mag_x;
    logic [DATA_W-1:0]        mag_y;
    logic [SQ_W-1:0]          r2;
  } sq_side_t;

  // side data carried alongside the dividers
  typedef struct packed {
    logic signed [DATA_W-1:0] vel_x;
    logic signed [DATA_W-1:0] vel_y;
    logic                     px_neg;
    logic                     py_neg;
    logic                     py_pos;
    logic                     near;
  } div_side_t;

  // clamped quotient magnitude to signed 32 bits
  function automatic logic signed [DATA_W-1:0] sat_quo(input logic [DATA_W-1:0] q,
                                                       input logic ovf,
                                                       input logic neg);
    logic signed [DATA_W-1:0] res;
    if (ovf) begin
      res = neg ? SAT_MIN : SAT_MAX;
    end else if (neg) begin
      res = (q > {1'b1, {(DATA_W-1){1'b0}}}) ? SAT_MIN : signed'({DATA_W{1'b0}} - q);
    end else begin
      res = q[DATA_W-1] ? SAT_MAX : signed'(q);
    end
    return res;
  endfunction

  // saturate a 65 bit signed value to signed 32 bits
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SQ_W:0] v);
    logic signed [DATA_W-1:0] res;
    if (v > (SQ_W+1)'(SAT_MAX)) begin
      res = SAT_MAX;
    end else if (v < (SQ_W+1)'(SAT_MIN)) begin
      res = SAT_MIN;
    end else begin
      res = v[DATA_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== design/rmj_div.sv =====
// pipelined restoring divider, one quotient bit per stage, overflow flag for clamping
module rmj_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [rmj_pkg::NUM_W-1:0]   num,
  input  logic [rmj_pkg::SQ_W-1:0]    den,
  output logic [rmj_pkg::DATA_W-1:0]  quo,
  output logic                        ovf
);
  import rmj_pkg::*;

  logic [SQ_W-1:0]   rem_r [0:DIV_STEPS];
  logic [DATA_W-1:0] lo_r  [0:DIV_STEPS];
  logic [SQ_W-1:0]   den_r [0:DIV_STEPS];
  logic [DATA_W-1:0] q_r   [0:DIV_STEPS];
  logic              ovf_r [0:DIV_STEPS];
  logic [SQ_W-1:0]   num_hi;
  logic              ovf_in;

  // a quotient of 2^32 or more is flagged as overflow
  assign num_hi = SQ_W'(num[NUM_W-1:DATA_W]);
  assign ovf_in = (num_hi >= den);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= ovf_in ? '0 : num_hi;
      lo_r[0]  <= num[DATA_W-1:0];
      den_r[0] <= den;
      q_r[0]   <= '0;
      ovf_r[0] <= ovf_in;
    end
  end

  // one compare and subtract per stage
  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
    logic [SQ_W:0] rem_w;
    logic [SQ_W:0] diff;
    logic          ge;
    assign rem_w = {rem_r[k-1], lo_r[k-1][DATA_W-1]};
    assign ge    = (rem_w >= {1'b0, den_r[k-1]});
    assign diff  = rem_w - {1'b0, den_r[k-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? diff[SQ_W-1:0] : rem_w[SQ_W-1:0];
        lo_r[k]  <= {lo_r[k-1][DATA_W-2:0], 1'b0};
        den_r[k] <= den_r[k-1];
        q_r[k]   <= {q_r[k-1][DATA_W-2:0], ge};
        ovf_r[k] <= ovf_r[k-1];
      end
    end
  end

  assign quo = q_r[DIV_STEPS];
  assign ovf = ovf_r[DIV_STEPS];

endmodule

// ===== design/radar_measurement_jacobian.sv =====
// radar measurement jacobian: range, ratios and range-rate terms in one pipeline
//
//   channel  direction  ports                          transaction
//   in       input      in_valid in_stall in_data      one tracking state
//   out      output     out_valid out_stall out_data   one set of jacobian terms
//   cfg      input      cfg_we cfg_index cfg_wdata     one register write
//
// one transaction per cycle unless a result is stalled; stages: magnitudes, squares and sum (3),
// a 32 stage square root, a divider entry stage, 33 divider stages (four dividers
// side by side) and five stages of fallback, products and saturation
// rst_n is synchronous; it clears valid bits and loads both registers with 1
// a stalled result freezes the whole pipeline, so nothing is lost or repeated
module radar_measurement_jacobian (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rmj_pkg::rmj_in_t    in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rmj_pkg::rmj_out_t   out_data,
  input  logic                cfg_we,
  input  rmj_pkg::cfg_idx_t   cfg_index,
  input  logic [rmj_pkg::CFG_W-1:0] cfg_wdata
);
  import rmj_pkg::*;

  logic                adv;
  logic [MINR_W-1:0]   min_range_r;
  logic [FB_W-1:0]     fallback_r;

  // pipeline advances unless a finished result is held
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_range_r <= MINR_W'(1);
      fallback_r  <= FB_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_RANGE: min_range_r <= cfg_wdata[MINR_W-1:0];
        CFG_FALLBACK:  fallback_r  <= cfg_wdata[FB_W-1:0];
        default:       min_range_r <= min_range_r;
      endcase
    end
  end

  // stage 1: magnitudes
  logic     v1_r;
  sq_side_t s1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r.vel_x  <= in_data.vel_x;
      s1_r.vel_y  <= in_data.vel_y;
      s1_r.px_neg <= in_data.pos_x[DATA_W-1];
      s1_r.py_neg <= in_data.pos_y[DATA_W-1];
      s1_r.py_pos <= !in_data.pos_y[DATA_W-1] && (in_data.pos_y != '0);
      s1_r.mag_x  <= in_data.pos_x[DATA_W-1] ? (DATA_W'(0) - in_data.pos_x) : in_data.pos_x;
      s1_r.mag_y  <= in_data.pos_y[DATA_W-1] ? (DATA_W'(0) - in_data.pos_y) : in_data.pos_y;
      s1_r.r2     <= '0;
    end
  end

  // stage 2: squares
  logic            v2_r;
  sq_side_t        s2_r;
  logic [SQ_W-1:0] sqx_r;
  logic [SQ_W-1:0] sqy_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_r  <= s1_r;
      sqx_r <= SQ_W'(s1_r.mag_x) * SQ_W'(s1_r.mag_x);
      sqy_r <= SQ_W'(s1_r.mag_y) * SQ_W'(s1_r.mag_y);
    end
  end

  // stage 3 (square root entry): sum of squares
  logic                sq_vld_r  [0:SQ_STEPS];
  sq_side_t            sq_side_r [0:SQ_STEPS];
  logic [DATA_W+1:0]   sq_rem_r  [0:SQ_STEPS];
  logic [DATA_W-1:0]   sq_root_r [0:SQ_STEPS];
  logic [SQ_W-1:0]     sq_rad_r  [0:SQ_STEPS];
  sq_side_t            sq_entry;

  // side data with the sum of squares filled in
  always_comb begin
    sq_entry    = s2_r;
    sq_entry.r2 = sqx_r + sqy_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r[0] <= 1'b0;
    end else if (adv) begin
      sq_vld_r[0] <= v2_r;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      sq_side_r[0]    <= sq_entry;
      sq_rem_r[0]     <= '0;
      sq_root_r[0]    <= '0;
      sq_rad_r[0]     <= sqx_r + sqy_r;
    end
  end

  // square root, one result bit per stage
  for (genvar k = 1; k <= SQ_STEPS; k++) begin : g_sqrt
    logic [DATA_W+3:0] rem_w;
    logic [DATA_W+3:0] trial;
    logic              ge;
    assign rem_w = {sq_rem_r[k-1], sq_rad_r[k-1][SQ_W-1:SQ_W-2]};
    assign trial = (DATA_W+4)'({sq_root_r[k-1], 2'b01});
    assign ge    = (rem_w >= trial);
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[k] <= 1'b0;
      end else if (adv) begin
        sq_vld_r[k] <= sq_vld_r[k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_side_r[k] <= sq_side_r[k-1];
        sq_rad_r[k]  <= {sq_rad_r[k-1][SQ_W-3:0], 2'b00};
        sq_rem_r[k]  <= ge ? (DATA_W+2)'(rem_w - trial) : rem_w[DATA_W+1:0];
        sq_root_r[k] <= {sq_root_r[k-1][DATA_W-2:0], ge};
      end
    end
  end

  // divider entry: near test, numerators and divisors
  logic              dv_vld_r  [0:DIV_LAT];
  div_side_t         dv_side_r [0:DIV_LAT];
  logic [NUM_W-1:0]  num_x1_r, num_y1_r, num_x2_r, num_y2_r;
  logic [SQ_W-1:0]   den_r1_r, den_r2_r;
  logic [DATA_W-1:0] r_fin;
  sq_side_t          sq_last;
  assign r_fin   = sq_root_r[SQ_STEPS];
  assign sq_last = sq_side_r[SQ_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r[0] <= 1'b0;
    end else if (adv) begin
      dv_vld_r[0] <= sq_vld_r[SQ_STEPS];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      dv_side_r[0].vel_x  <= sq_last.vel_x;
      dv_side_r[0].vel_y  <= sq_last.vel_y;
      dv_side_r[0].px_neg <= sq_last.px_neg;
      dv_side_r[0].py_neg <= sq_last.py_neg;
      dv_side_r[0].py_pos <= sq_last.py_pos;
      dv_side_r[0].near   <= (r_fin == '0) || (r_fin < DATA_W'(min_range_r));
      num_x1_r <= NUM_W'({sq_last.mag_x, {FRAC_BITS{1'b0}}});
      num_y1_r <= NUM_W'({sq_last.mag_y, {FRAC_BITS{1'b0}}});
      num_x2_r <= {sq_last.mag_x, {(2*FRAC_BITS){1'b0}}};
      num_y2_r <= {sq_last.mag_y, {(2*FRAC_BITS){1'b0}}};
      den_r1_r <= SQ_W'(r_fin);
      den_r2_r <= sq_last.r2;
    end
  end

  // side data delay matching the dividers
  for (genvar k = 1; k <= DIV_LAT; k++) begin : g_dside
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[k] <= 1'b0;
      end else if (adv) begin
        dv_vld_r[k] <= dv_vld_r[k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_side_r[k] <= dv_side_r[k-1];
      end
    end
  end

  logic [DATA_W-1:0] q_x1, q_y1, q_x2, q_y2;
  logic              o_x1, o_y1, o_x2, o_y2;

  rmj_div u_div_x1 (.clk(clk), .en(adv), .num(num_x1_r), .den(den_r1_r), .quo(q_x1), .ovf(o_x1));
  rmj_div u_div_y1 (.clk(clk), .en(adv), .num(num_y1_r), .den(den_r1_r), .quo(q_y1), .ovf(o_y1));
  rmj_div u_div_x2 (.clk(clk), .en(adv), .num(num_x2_r), .den(den_r2_r), .quo(q_x2), .ovf(o_x2));
  rmj_div u_div_y2 (.clk(clk), .en(adv), .num(num_y2_r), .den(den_r2_r), .quo(q_y2), .ovf(o_y2));

  // saturation or fallback of the four ratio terms
  div_side_t                dl;
  logic                     ve_r;
  logic signed [DATA_W-1:0] h11_r, h12_r, h21_r, h22_r;
  logic signed [DATA_W-1:0] vxe_r, vye_r;
  logic                     near_e_r;
  logic signed [DATA_W-1:0] fb_pos, fb_neg;
  assign dl     = dv_side_r[DIV_LAT];
  assign fb_pos = signed'(DATA_W'(fallback_r));
  assign fb_neg = DATA_W'(0) - fb_pos;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
    end else if (adv) begin
      ve_r <= dv_vld_r[DIV_LAT];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      h11_r    <= dl.near ? fb_pos : sat_quo(q_x1, o_x1, dl.px_neg);
      h12_r    <= dl.near ? fb_pos : sat_quo(q_y1, o_y1, dl.py_neg);
      h21_r    <= dl.near ? fb_neg : sat_quo(q_y2, o_y2, dl.py_pos);
      h22_r    <= dl.near ? fb_pos : sat_quo(q_x2, o_x2, dl.px_neg);
      vxe_r    <= dl.vel_x;
      vye_r    <= dl.vel_y;
      near_e_r <= dl.near;
    end
  end

  // velocity products
  logic                     vm1_r;
  logic signed [SQ_W-1:0]   p1_r, p2_r;
  logic signed [DATA_W-1:0] h11_m_r, h12_m_r, h21_m_r, h22_m_r;
  logic                     near_m_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm1_r <= 1'b0;
    end else if (adv) begin
      vm1_r <= ve_r;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      p1_r     <= SQ_W'(vye_r) * SQ_W'(h11_r);
      p2_r     <= SQ_W'(vxe_r) * SQ_W'(h12_r);
      h11_m_r  <= h11_r;
      h12_m_r  <= h12_r;
      h21_m_r  <= h21_r;
      h22_m_r  <= h22_r;
      near_m_r <= near_e_r;
    end
  end

  // coupling factor t
  logic                     vt_r;
  logic signed [DATA_W-1:0] t_r;
  logic signed [DATA_W-1:0] h11_t_r, h12_t_r, h21_t_r, h22_t_r;
  logic                     near_t_r;
  logic signed [SQ_W:0]     pdiff;
  logic signed [SQ_W:0]     pdiff_sh;
  assign pdiff    = (SQ_W+1)'(p1_r) - (SQ_W+1)'(p2_r);
  assign pdiff_sh = pdiff >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vt_r <= 1'b0;
    end else if (adv) begin
      vt_r <= vm1_r;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      t_r      <= sat32(pdiff_sh);
      h11_t_r  <= h11_m_r;
      h12_t_r  <= h12_m_r;
      h21_t_r  <= h21_m_r;
      h22_t_r  <= h22_m_r;
      near_t_r <= near_m_r;
    end
  end

  // range-rate products
  logic                     vm2_r;
  logic signed [SQ_W-1:0]   m1_r, m2_r;
  logic signed [DATA_W-1:0] h11_2_r, h12_2_r, h21_2_r, h22_2_r;
  logic                     near_2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm2_r <= 1'b0;
    end else if (adv) begin
      vm2_r <= vt_r;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      m1_r     <= SQ_W'(t_r) * SQ_W'(h21_t_r);
      m2_r     <= SQ_W'(t_r) * SQ_W'(h22_t_r);
      h11_2_r  <= h11_t_r;
      h12_2_r  <= h12_t_r;
      h21_2_r  <= h21_t_r;
      h22_2_r  <= h22_t_r;
      near_2_r <= near_t_r;
    end
  end

  // output register
  logic                 vo_r;
  rmj_out_t             out_r;
  logic signed [SQ_W:0] m1_sh, m2_sh;
  assign m1_sh = (SQ_W+1)'(m1_r) >>> FRAC_BITS;
  assign m2_sh = (SQ_W+1)'(m2_r) >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (adv) begin
      vo_r <= vm2_r;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      out_r.range_dx    <= h11_2_r;
      out_r.range_dy    <= h12_2_r;
      out_r.bearing_dx  <= h21_2_r;
      out_r.bearing_dy  <= h22_2_r;
      out_r.rate_dx     <= sat32(m1_sh);
      out_r.rate_dy     <= sat32(m2_sh);
      out_r.near_origin <= near_2_r;
    end
  end

  assign out_valid = vo_r;
  assign out_data  = out_r;

  // near the origin the ratio terms carry the fallback value (bearing_dx its negation)
  a_fallback: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.near_origin) |->
      (out_data.range_dx == fb_pos && out_data.bearing_dx == fb_neg))
    else $error("fallback terms do not match fallback value");

  // away from the origin px over range stays within two
  a_ratio_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.near_origin) |->
      (out_data.range_dx <= 32'sd131072 && out_data.range_dx >= -32'sd131072))
    else $error("range ratio out of bounds");

  // no result straight after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule
